// ----- sv/texture_coordinate_rotator_unit_defines.svh -----
// Assertion macros shared by the texture coordinate rotator RTL.
`ifndef TEXTURE_COORDINATE_ROTATOR_UNIT_DEFINES_SVH
`define TEXTURE_COORDINATE_ROTATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TCR_ASSERT_NOW(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCR_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tcr_pkg.sv -----
// Package: constants and sine table helpers for the texture coordinate rotator.
package tcr_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	// pi/2 in Q2.30 radians
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [31:0] SPEED_RESET = 32'd10430;

	// item kinds
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_VERTEX = 1'b1;

	// quadrant codes, top two bits of the phase
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// 1.0 in the Q.27 product domain
	localparam logic signed [35:0] ONE_Q27 = 36'sd134217728;
	// half an LSB of Q4.12 in Q.28 before the final shift
	localparam logic signed [35:0] HALF_LSB = 36'sd32768;

	// sin(x), x in Q2.30 radians, Taylor series through x^15, result Q0.15
	function automatic logic [14:0] rom_sine_q15(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - term;
		r    = (sum + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[14:0];
	endfunction

	// clamp a rounded coordinate to signed 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [19:0] r);
		logic signed [15:0] y;
		if (r > 20'sd32767) begin
			y = 16'sh7fff;
		end else if (r < -20'sd32768) begin
			y = -16'sh8000;
		end else begin
			y = r[15:0];
		end
		return y;
	endfunction

endpackage

// ----- sv/texture_coordinate_rotator_unit.sv -----
// Top level: time-driven rotation of texture coordinates about the texture center.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word per item. cmd selects a time tick
//    (elapsed_time) or a vertex (tex_u, tex_v, last_in). A word is taken at a rising
//    edge with in_valid high and in_stall low. One word per cycle is sustained while out_stall stays low.
//  - Output channel (out_valid / out_stall): one word (out_u, out_v, last_out) per
//    vertex, in input order. Ticks give no output word.
//  - Config channel (cfg_valid / cfg_ready, rotation_speed): cfg_ready is always high;
//    write only while the block is idle.
//  - Path: a vertex passes stage registers 1 to 6, then the output register. A tick takes
//    effect on every vertex taken after it, also one taken in the very next cycle,
//    since both travel the same in-order pipe and the tick updates sine/cosine
//    one stage ahead of the vertex multipliers.
//  - The 1-cycle rate is set by the seven-stage pipe: tick multiply, phase add,
//    index multiply, sine table read, then vertex multiply and round/saturate.
//  - Reset: phase, sine and cosine go to zero (vertices before any tick give 0.5,
//    0.5), speed goes to its default, pipe empties. No clearing pass is needed.
//  - When the receiver stalls, the held word stays put; stages behind it keep
//    filling any bubbles, and in_stall rises only once the pipe is full.
module texture_coordinate_rotator_unit
	import tcr_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [15:0]        elapsed_time,
	input  logic signed [15:0] tex_u,
	input  logic signed [15:0] tex_v,
	input  logic               last_in,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_u,
	output logic signed [15:0] out_v,
	output logic               last_out,
	// config channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        rotation_speed
);

`include "texture_coordinate_rotator_unit_defines.svh"

	// table address width: entries 0..SINE_TABLE_DEPTH
	localparam int AddrW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam logic [AddrW-1:0] DepthC = AddrW'(SINE_TABLE_DEPTH);

	// ------------------------------------------------------------------
	// quarter-wave sine ROM, contents fixed at elaboration
	// ------------------------------------------------------------------
	logic [14:0] sine_rom [SINE_TABLE_DEPTH + 1];

	for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [63:0] AngleQ30 =
			(64'(gi) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
		assign sine_rom[gi] = rom_sine_q15(AngleQ30);
	end

	// ------------------------------------------------------------------
	// architectural state
	// ------------------------------------------------------------------
	logic [31:0]        speed_q;
	logic [31:0]        phase_q;
	logic signed [15:0] sine_q;
	logic signed [15:0] cosine_q;

	// ------------------------------------------------------------------
	// pipe registers
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	logic [15:0]        el_s1;
	logic signed [15:0] u_s1, v_in_s1;

	logic [31:0]        prod_s2;                 // tick: speed * elapsed, low word
	logic signed [17:0] a_s2, a_s3, a_s4, a_s5;  // vertex: 2u - 1 in Q6.12
	logic signed [17:0] b_s2, b_s3, b_s4, b_s5;  // vertex: 2v - 1 in Q6.12

	logic [AddrW-1:0]   idx_s4;
	logic [1:0]         quad_s4, quad_s5;
	logic [14:0]        s0_s5, c0_s5;

	logic signed [33:0] ac_s6, bs_s6, bc_s6, as_s6;

	// ------------------------------------------------------------------
	// flow control: a stage loads when empty or when it drains this cycle
	// ------------------------------------------------------------------
	logic en_out, en_s6, en_s5, en_s4, en_s3, en_s2, en_s1;

	assign en_out = !out_valid || !out_stall;
	assign en_s6  = !v_s6 || en_out;
	assign en_s5  = !v_s5 || en_s6;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;

	assign in_stall  = !en_s1;
	assign cfg_ready = 1'b1;

	logic tick_s2_go, tick_s5_go;
	assign tick_s2_go = v_s2 && (cmd_s2 == CMD_TICK) && en_s3;
	assign tick_s5_go = v_s5 && (cmd_s5 == CMD_TICK) && en_s6;

	// ------------------------------------------------------------------
	// combinational pieces between registers
	// ------------------------------------------------------------------
	logic [47:0]        tick_prod;
	logic [AddrW+29:0]  frac_prod;
	logic [AddrW-1:0]   idx_nxt;
	logic signed [15:0] s0_x, c0_x;
	logic signed [15:0] sine_nxt, cosine_nxt;
	logic signed [35:0] sum_u, sum_v;
	logic signed [19:0] rnd_u, rnd_v;

	assign tick_prod = speed_q * el_s1;
	assign frac_prod = phase_q[29:0] * DepthC;
	assign idx_nxt   = frac_prod[30 +: AddrW];

	assign s0_x = signed'({1'b0, s0_s5});
	assign c0_x = signed'({1'b0, c0_s5});

	always_comb begin
		unique case (quad_s5)
			QUAD_0: begin
				sine_nxt   = s0_x;
				cosine_nxt = c0_x;
			end
			QUAD_1: begin
				sine_nxt   = c0_x;
				cosine_nxt = -s0_x;
			end
			QUAD_2: begin
				sine_nxt   = -s0_x;
				cosine_nxt = -c0_x;
			end
			QUAD_3: begin
				sine_nxt   = -c0_x;
				cosine_nxt = s0_x;
			end
		endcase
	end

	// u' and v' in Q.28, plus half LSB; floor shift gives round half up
	assign sum_u = 36'(ac_s6) + 36'(bs_s6) + ONE_Q27 + HALF_LSB;
	assign sum_v = 36'(bc_s6) - 36'(as_s6) + ONE_Q27 + HALF_LSB;
	assign rnd_u = signed'(sum_u[35:16]);
	assign rnd_v = signed'(sum_v[35:16]);

	// ------------------------------------------------------------------
	// control and state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= SPEED_RESET;
			phase_q   <= '0;
			sine_q    <= '0;
			cosine_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				speed_q <= rotation_speed;
			end
			// phase moves as a tick enters stage 3
			if (tick_s2_go) begin
				phase_q <= phase_q + prod_s2;
			end
			// sine/cosine update as a tick leaves stage 5
			if (tick_s5_go) begin
				sine_q   <= sine_nxt;
				cosine_q <= cosine_nxt;
			end
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			// ticks end at stage 5
			if (en_s6) begin
				v_s6 <= v_s5 && (cmd_s5 == CMD_VERTEX);
			end
			if (en_out) begin
				out_valid <= v_s6;
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1  <= cmd;
			el_s1   <= elapsed_time;
			u_s1    <= tex_u;
			v_in_s1 <= tex_v;
			last_s1 <= last_in;
		end
		if (en_s2) begin
			cmd_s2  <= cmd_s1;
			last_s2 <= last_s1;
			prod_s2 <= tick_prod[31:0];
			a_s2    <= signed'({u_s1[15], u_s1, 1'b0}) - 18'sd4096;
			b_s2    <= signed'({v_in_s1[15], v_in_s1, 1'b0}) - 18'sd4096;
		end
		if (en_s3) begin
			cmd_s3  <= cmd_s2;
			last_s3 <= last_s2;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
		end
		if (en_s4) begin
			cmd_s4  <= cmd_s3;
			last_s4 <= last_s3;
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			idx_s4  <= idx_nxt;
			quad_s4 <= phase_q[31:30];
		end
		if (en_s5) begin
			cmd_s5  <= cmd_s4;
			last_s5 <= last_s4;
			a_s5    <= a_s4;
			b_s5    <= b_s4;
			quad_s5 <= quad_s4;
			s0_s5   <= sine_rom[idx_s4];
			c0_s5   <= sine_rom[DepthC - idx_s4];
		end
		if (en_s6) begin
			last_s6 <= last_s5;
			ac_s6   <= a_s5 * cosine_q;
			bs_s6   <= b_s5 * sine_q;
			bc_s6   <= b_s5 * cosine_q;
			as_s6   <= a_s5 * sine_q;
		end
		if (en_out) begin
			out_u    <= sat16(rnd_u);
			out_v    <= sat16(rnd_v);
			last_out <= last_s6;
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`TCR_ASSERT_NEXT(a_phase_only_on_tick, clk, arst_n, !tick_s2_go, $stable(phase_q),
		"phase changed without a tick entering stage 3")
	`TCR_ASSERT_NEXT(a_trig_only_on_tick, clk, arst_n, !tick_s5_go,
		$stable(sine_q) && $stable(cosine_q),
		"sine/cosine changed without a tick leaving stage 5")
	`TCR_ASSERT_NEXT(a_no_invented_word, clk, arst_n, en_out && !v_s6, !out_valid,
		"output word appeared with no vertex behind it")
	`TCR_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, in_stall,
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && out_valid && out_stall,
		"input stalled while the pipe had room")

endmodule
